// File: hdl/blsp_pkg.sv
// Shared types and constants of the Bresenham line stepper.
package blsp_pkg;

  localparam int unsigned CoordW      = 6;   // port width of a coordinate
  localparam int unsigned CoordBitsDef = 6;  // default tile size exponent
  localparam int unsigned ErrW        = CoordW + 3;
  localparam int unsigned LineQDepth  = 2;

  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } blsp_req_t;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic              last_pixel;
  } blsp_pixel_t;

  // Classified line, ready to walk.
  typedef struct packed {
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] major_end;
    logic [ErrW-1:0]   err;     // signed start decision value
    logic [ErrW-1:0]   inc_a;   // signed, added when the minor axis stays
    logic [ErrW-1:0]   inc_b;   // signed, added when the minor axis moves
    logic              minor_up;
    logic              y_major;
  } blsp_line_t;

  typedef struct packed {
    logic empty;
    logic full;
  } blsp_qstat_t;

endpackage

// File: hdl/blsp_front.sv
// Front end: classifies a line request into walking parameters.
module blsp_front #(
  parameter int unsigned COORD_BITS = blsp_pkg::CoordBitsDef
) (
  input  blsp_pkg::blsp_req_t  req_i,
  output blsp_pkg::blsp_line_t line_o
);
  import blsp_pkg::*;

  localparam logic [CoordW-1:0] CoordMask = CoordW'((1 << COORD_BITS) - 1);

  logic [CoordW-1:0] sx, sy, ex, ey;
  logic signed [CoordW:0] dx, dy;
  logic [CoordW-1:0] adx, ady, maj_abs, min_abs;
  logic y_major, neg_major;

  always_comb begin
    sx = req_i.start_x & CoordMask;
    sy = req_i.start_y & CoordMask;
    ex = req_i.end_x & CoordMask;
    ey = req_i.end_y & CoordMask;
    dx = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy = $signed({1'b0, ey}) - $signed({1'b0, sy});
    adx = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
    ady = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
    y_major = ady > adx;
    maj_abs = y_major ? ady : adx;
    min_abs = y_major ? adx : ady;
    neg_major = y_major ? dy[CoordW] : dx[CoordW];

    // walk always runs toward the larger major coordinate
    line_o.start_x   = neg_major ? ex : sx;
    line_o.start_y   = neg_major ? ey : sy;
    if (y_major) begin
      line_o.major_end = neg_major ? sy : ey;
    end else begin
      line_o.major_end = neg_major ? sx : ex;
    end
    line_o.err   = {2'b00, min_abs, 1'b0} - {3'b000, maj_abs};
    line_o.inc_a = {2'b00, min_abs, 1'b0};
    line_o.inc_b = {2'b00, min_abs, 1'b0} - {2'b00, maj_abs, 1'b0};
    line_o.minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
    line_o.y_major  = y_major;
  end

endmodule

// File: hdl/blsp_line_q.sv
// Short queue of classified lines between front end and walker.
module blsp_line_q #(
  parameter int unsigned DEPTH = blsp_pkg::LineQDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  blsp_pkg::blsp_line_t wdata_i,
  input  logic                 rd_i,
  output blsp_pkg::blsp_line_t rdata_o,
  output blsp_pkg::blsp_qstat_t stat_o
);
  import blsp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  blsp_line_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign do_wr = wr_i && !stat_o.full;
  assign do_rd = rd_i && !stat_o.empty;
  assign rdata_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hdl/blsp_walker.sv
// Back end: walks one line a pixel per cycle into the output register, while that register is free or popped.
module blsp_walker #(
  parameter int unsigned COORD_BITS = blsp_pkg::CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  blsp_pkg::blsp_line_t line_i,
  input  logic                 line_avail_i,
  output logic                 line_take_o,
  output logic                 active_o,
  output logic                 empty,
  input  logic                 pop,
  output blsp_pkg::blsp_pixel_t pixel_o
);
  import blsp_pkg::*;

  localparam logic [CoordW-1:0] CoordMask = CoordW'((1 << COORD_BITS) - 1);

  logic              active_q, active_d;
  logic              out_vld_q, out_vld_d;
  blsp_pixel_t       out_q, out_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d, end_q, end_d;
  logic [ErrW-1:0]   err_q, err_d, inc_a_q, inc_a_d, inc_b_q, inc_b_d;
  logic              up_q, up_d, ymaj_q, ymaj_d;

  logic              slot_free, step, last, move_minor;
  logic [CoordW-1:0] minor_cur, minor_nxt;

  assign slot_free   = !out_vld_q || pop;
  assign step        = active_q && slot_free;
  assign line_take_o = !active_q && line_avail_i;
  assign active_o    = active_q;
  assign empty       = !out_vld_q;
  assign pixel_o     = out_q;

  always_comb begin
    last       = ymaj_q ? (y_q == end_q) : (x_q == end_q);
    // x-major moves on err >= 0, y-major only on err > 0
    move_minor = ymaj_q ? ($signed(err_q) > 0) : ($signed(err_q) >= 0);
    minor_cur  = ymaj_q ? x_q : y_q;
    minor_nxt  = (up_q ? minor_cur + 1'b1 : minor_cur - 1'b1) & CoordMask;
  end

  always_comb begin
    active_d  = active_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    x_d       = x_q;
    y_d       = y_q;
    end_d     = end_q;
    err_d     = err_q;
    inc_a_d   = inc_a_q;
    inc_b_d   = inc_b_q;
    up_d      = up_q;
    ymaj_d    = ymaj_q;
    if (line_take_o) begin
      active_d = 1'b1;
      x_d      = line_i.start_x;
      y_d      = line_i.start_y;
      end_d    = line_i.major_end;
      err_d    = line_i.err;
      inc_a_d  = line_i.inc_a;
      inc_b_d  = line_i.inc_b;
      up_d     = line_i.minor_up;
      ymaj_d   = line_i.y_major;
    end
    if (slot_free) begin
      out_vld_d = 1'b0;
    end
    if (step) begin
      out_vld_d        = 1'b1;
      out_d.pixel_x    = x_q;
      out_d.pixel_y    = y_q;
      out_d.last_pixel = last;
      if (last) begin
        active_d = 1'b0;
      end else begin
        err_d = err_q + (move_minor ? inc_b_q : inc_a_q);
        if (ymaj_q) begin
          y_d = y_q + 1'b1;
          if (move_minor) begin
            x_d = minor_nxt;
          end
        end else begin
          x_d = x_q + 1'b1;
          if (move_minor) begin
            y_d = minor_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    x_q     <= x_d;
    y_q     <= y_d;
    end_q   <= end_d;
    err_q   <= err_d;
    inc_a_q <= inc_a_d;
    inc_b_q <= inc_b_d;
    up_q    <= up_d;
    ymaj_q  <= ymaj_d;
  end

endmodule

// File: hdl/bresenham_line_stepper.sv
// Bresenham line stepper: one line request in, its pixel run out.
//
// Input channel: a request (two endpoints) is taken when push is high and
// full is low. The front end classifies it at once and places it in a
// two-entry line queue, so requests are taken while a line is being walked.
// Output channel: while empty is low, pixel_o holds the oldest pixel; it is
// taken when pop is high. The final pixel of a line has last_pixel set.
// Pixels run from the endpoint with the smaller major-axis coordinate.
// A request passes the line queue, the walker's line registers and the output
// register before its first pixel shows. The walker loads a line when idle,
// then emits one pixel a cycle while the receiver keeps taking them; the
// walker loop and its single output register set this rate.
// When the receiver stalls, the walker holds its pixel and waits; the queue
// fills and full rises after two more requests.
// Reset clears the queue, the walker and the output register; no item is
// held afterwards.
module bresenham_line_stepper #(
  parameter int unsigned COORD_BITS = blsp_pkg::CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  blsp_pkg::blsp_req_t   req_i,
  output logic                  empty,
  input  logic                  pop,
  output blsp_pkg::blsp_pixel_t pixel_o
);
  import blsp_pkg::*;

  blsp_line_t  fr_line, q_line;
  blsp_qstat_t q_stat;
  logic        q_take, walk_active;

  assign full = q_stat.full;

  blsp_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .req_i (req_i),
    .line_o(fr_line)
  );

  blsp_line_q #(
    .DEPTH(LineQDepth)
  ) u_line_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push),
    .wdata_i(fr_line),
    .rd_i   (q_take),
    .rdata_o(q_line),
    .stat_o (q_stat)
  );

  blsp_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_i      (q_line),
    .line_avail_i(!q_stat.empty),
    .line_take_o (q_take),
    .active_o    (walk_active),
    .empty       (empty),
    .pop         (pop),
    .pixel_o     (pixel_o)
  );

  // a pixel that is not the last one means the line is still being walked
  a_mid_line_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pixel_o.last_pixel) |-> walk_active)
    else $error("pixel without last flag while walker idle");

  // popping a mid-line pixel refills the output register right away
  a_no_gap_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !pixel_o.last_pixel) |=> !empty)
    else $error("gap in pixel run");

  // a request into an empty queue makes it non-empty in the next cycle
  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && q_stat.empty) |=> !q_stat.empty)
    else $error("accepted request lost in line queue");

endmodule
